// ===== hdl/mac_learning_bridge_forward_core_assert.svh =====
// Assertion macros for the bridge forwarding core checker.
`ifndef MAC_LEARNING_BRIDGE_FORWARD_CORE_ASSERT_SVH
`define MAC_LEARNING_BRIDGE_FORWARD_CORE_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define MLBF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("mlbf assertion failed");

// Check a property on every rising clock edge, reset included.
`define MLBF_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("mlbf assertion failed during reset");

`endif

// ===== hdl/mlbf_pkg.sv =====
`timescale 1ns / 1ps

package mlbf_pkg;

  localparam int unsigned TABLE_ENTRIES = 64;
  localparam int unsigned PORT_COUNT    = 8;
  localparam int unsigned MAC_BYTES     = 6;
  localparam int unsigned MAC_W         = MAC_BYTES * 8;
  localparam int unsigned PORT_W        = 3;
  localparam int unsigned MASK_W        = 8;
  localparam int unsigned LEN_W         = 14;
  localparam int unsigned HEADER_BYTES  = 2 * MAC_BYTES + 2;

  localparam logic [MAC_W-1:0]  BCAST_MAC     = '1;
  localparam logic [MASK_W-1:0] PRESENT_RESET = 8'hFF;
  localparam logic [MASK_W-1:0] PORT_LIMIT_MASK =
      (PORT_COUNT >= MASK_W) ? '1 : MASK_W'((1 << PORT_COUNT) - 1);

  typedef enum logic {
    CMD_FRAME   = 1'b0,
    CMD_INSTALL = 1'b1
  } cmd_e;

  typedef struct packed {
    logic load;
    logic read;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic table_empty;
    logic scan_last;
  } ctrl_stat_t;

endpackage

// ===== hdl/mlbf_if.sv =====
`timescale 1ns / 1ps

interface mlbf_item_if;
  logic                        valid;
  logic                        ready;
  logic [0:0]                  cmd;
  logic [mlbf_pkg::PORT_W-1:0] ingress_port;
  logic [mlbf_pkg::MAC_W-1:0]  src_mac;
  logic [mlbf_pkg::MAC_W-1:0]  dst_mac;
  logic [mlbf_pkg::LEN_W-1:0]  frame_length;

  modport source (output valid, cmd, ingress_port, src_mac, dst_mac, frame_length,
                  input ready);
  modport sink   (input valid, cmd, ingress_port, src_mac, dst_mac, frame_length,
                  output ready);
endinterface

interface mlbf_result_if;
  logic                        valid;
  logic                        ready;
  logic [mlbf_pkg::MASK_W-1:0] forward_mask;
  logic                        learned;
  logic                        local_rx;
  logic                        table_full;

  modport source (output valid, forward_mask, learned, local_rx, table_full,
                  input ready);
  modport sink   (input valid, forward_mask, learned, local_rx, table_full,
                  output ready);
endinterface

interface mlbf_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [mlbf_pkg::MASK_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== hdl/mlbf_ram.sv =====
`timescale 1ns / 1ps

module mlbf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hdl/mlbf_datapath.sv =====
`timescale 1ns / 1ps

module mlbf_datapath #(
  parameter int unsigned TABLE_ENTRIES = mlbf_pkg::TABLE_ENTRIES
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mlbf_pkg::ctrl_cmd_t         cmd_i,
  output mlbf_pkg::ctrl_stat_t        stat_o,
  input  logic [0:0]                  cmd_field_i,
  input  logic [mlbf_pkg::PORT_W-1:0] ingress_port_i,
  input  logic [mlbf_pkg::MAC_W-1:0]  src_mac_i,
  input  logic [mlbf_pkg::MAC_W-1:0]  dst_mac_i,
  input  logic [mlbf_pkg::LEN_W-1:0]  frame_length_i,
  input  logic                        cfg_valid_i,
  input  logic [mlbf_pkg::MASK_W-1:0] cfg_data_i,
  output logic [mlbf_pkg::MASK_W-1:0] forward_mask_o,
  output logic                        learned_o,
  output logic                        local_rx_o,
  output logic                        table_full_o
);

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned ENT_W = mlbf_pkg::PORT_W + mlbf_pkg::MAC_W;

  logic [0:0]                  cmd_q;
  logic [mlbf_pkg::PORT_W-1:0] port_q;
  logic [mlbf_pkg::MAC_W-1:0]  src_q;
  logic [mlbf_pkg::MAC_W-1:0]  dst_q;
  logic [mlbf_pkg::LEN_W-1:0]  len_q;

  logic [mlbf_pkg::MASK_W-1:0] present_q;
  logic [CNT_W-1:0]            fill_q, fill_d;

  logic [IDX_W-1:0]            scan_addr_q;
  logic                        rd_pend_q;
  logic [IDX_W-1:0]            rd_idx_q;

  logic                        src_found_q, dst_found_q;
  logic [IDX_W-1:0]            src_idx_q;
  logic [mlbf_pkg::PORT_W-1:0] src_port_q, dst_port_q;

  logic [mlbf_pkg::MASK_W-1:0] fwd_q;
  logic                        learned_q, local_q, full_q;

  logic [ENT_W-1:0]            rd_data;
  logic [mlbf_pkg::MAC_W-1:0]  rd_mac;
  logic [mlbf_pkg::PORT_W-1:0] rd_port;

  logic                        wr_en;
  logic [IDX_W-1:0]            wr_addr;
  logic [mlbf_pkg::MASK_W-1:0] fwd_d;
  logic                        learned_d, local_d, full_d;
  logic                        at_capacity, src_bc, dst_bc, flood;
  logic [mlbf_pkg::MASK_W-1:0] port_bit;

  assign rd_mac  = rd_data[mlbf_pkg::MAC_W-1:0];
  assign rd_port = rd_data[ENT_W-1:mlbf_pkg::MAC_W];

  assign stat_o.table_empty = (fill_q == '0);
  assign stat_o.scan_last   = (CNT_W'(scan_addr_q) == fill_q - CNT_W'(1));

  mlbf_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en && cmd_i.commit),
    .wr_addr_i (wr_addr),
    .wr_data_i ({port_q, src_q}),
    .rd_en_i   (cmd_i.read),
    .rd_addr_i (scan_addr_q),
    .rd_data_o (rd_data)
  );

  always_comb begin
    at_capacity = (fill_q == CNT_W'(TABLE_ENTRIES));
    src_bc      = (src_q == mlbf_pkg::BCAST_MAC);
    dst_bc      = (dst_q == mlbf_pkg::BCAST_MAC);
    port_bit    = mlbf_pkg::MASK_W'(1) << port_q;
    wr_en       = 1'b0;
    wr_addr     = fill_q[IDX_W-1:0];
    fwd_d       = '0;
    learned_d   = 1'b0;
    local_d     = 1'b0;
    full_d      = 1'b0;
    flood       = 1'b0;
    fill_d      = fill_q;
    if (cmd_q == mlbf_pkg::CMD_INSTALL) begin
      if (!src_bc) begin
        if (src_found_q) begin
          wr_en   = 1'b1;
          wr_addr = src_idx_q;
        end else if (!at_capacity) begin
          wr_en     = 1'b1;
          learned_d = 1'b1;
          fill_d    = fill_q + CNT_W'(1);
        end else begin
          full_d = 1'b1;
        end
      end
    end else if (len_q >= mlbf_pkg::LEN_W'(mlbf_pkg::HEADER_BYTES)) begin
      if (src_found_q) begin
        local_d = (src_port_q == port_q);
      end else if (!src_bc) begin
        local_d = 1'b1;
        if (!at_capacity) begin
          wr_en     = 1'b1;
          learned_d = 1'b1;
          fill_d    = fill_q + CNT_W'(1);
        end else begin
          full_d = 1'b1;
        end
      end
      flood = dst_bc || !dst_found_q;
      if (!flood && (dst_port_q != port_q)) begin
        fwd_d = mlbf_pkg::MASK_W'(1) << dst_port_q;
      end
      if (flood && local_d) begin
        fwd_d = present_q & mlbf_pkg::PORT_LIMIT_MASK & ~port_bit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= mlbf_pkg::PRESENT_RESET;
      fill_q    <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        present_q <= cfg_data_i;
      end
      if (cmd_i.commit) begin
        fill_q <= fill_d;
      end
      rd_pend_q <= cmd_i.read;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q       <= cmd_field_i;
      port_q      <= ingress_port_i;
      src_q       <= src_mac_i;
      dst_q       <= dst_mac_i;
      len_q       <= frame_length_i;
      scan_addr_q <= '0;
      src_found_q <= 1'b0;
      dst_found_q <= 1'b0;
    end else begin
      if (cmd_i.read) begin
        scan_addr_q <= scan_addr_q + IDX_W'(1);
      end
      if (rd_pend_q) begin
        if (!src_found_q && (rd_mac == src_q)) begin
          src_found_q <= 1'b1;
          src_idx_q   <= rd_idx_q;
          src_port_q  <= rd_port;
        end
        if (!dst_found_q && (rd_mac == dst_q)) begin
          dst_found_q <= 1'b1;
          dst_port_q  <= rd_port;
        end
      end
    end
    rd_idx_q <= scan_addr_q;
    if (cmd_i.commit) begin
      fwd_q     <= fwd_d;
      learned_q <= learned_d;
      local_q   <= local_d;
      full_q    <= full_d;
    end
  end

  assign forward_mask_o = fwd_q;
  assign learned_o      = learned_q;
  assign local_rx_o     = local_q;
  assign table_full_o   = full_q;

endmodule

// ===== hdl/mlbf_ctrl.sv =====
`timescale 1ns / 1ps

module mlbf_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output mlbf_pkg::ctrl_cmd_t  cmd_o,
  input  mlbf_pkg::ctrl_stat_t stat_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH,
    ST_DECIDE
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_SCAN: begin
        cmd_o.read = 1'b1;
      end
      ST_FLUSH: begin
      end
      ST_DECIDE: begin
        cmd_o.commit = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == ST_DECIDE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= stat_i.table_empty ? ST_DECIDE : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (stat_i.scan_last) begin
            state_q <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          state_q <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hdl/mac_learning_bridge_forward_core.sv =====
`timescale 1ns / 1ps
// Learning bridge forwarding decision core.
// item_i carries one beat per frame header (cmd 0) or table install (cmd 1);
// every beat yields exactly one beat on result_o, in order.
// cfg_i writes the present-ports mask; it is always ready and takes effect at
// once; it must be written only while the core is idle, which is not enforced.
// After the item is accepted, the single read port of the MAC table is swept
// one entry per cycle over the entries in use, source and destination compared
// together; a flush state then drains the read register and a decide state
// commits the learn write and raises the result beat. With an empty table the
// sweep and flush are skipped. The next item can be taken in the cycle after
// the result beat is raised at the earliest.
// Only one item is in flight; item_i.ready is high while the core is idle.
// If result_o stalls, the finished result is held and the core still takes
// the next item, waiting to commit it until the result register is free.
// Reset empties the table (fill count to zero), sets the mask to all ones
// and drops any pending result; no clearing pass is needed.
module mac_learning_bridge_forward_core #(
  parameter int unsigned TABLE_ENTRIES = mlbf_pkg::TABLE_ENTRIES
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  mlbf_item_if.sink     item_i,
  mlbf_result_if.source result_o,
  mlbf_cfg_if.sink      cfg_i
);

  mlbf_pkg::ctrl_cmd_t  cmd;
  mlbf_pkg::ctrl_stat_t stat;

  assign cfg_i.ready = 1'b1;

  mlbf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_ready_o  (item_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  mlbf_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .cmd_field_i    (item_i.cmd),
    .ingress_port_i (item_i.ingress_port),
    .src_mac_i      (item_i.src_mac),
    .dst_mac_i      (item_i.dst_mac),
    .frame_length_i (item_i.frame_length),
    .cfg_valid_i    (cfg_i.valid),
    .cfg_data_i     (cfg_i.data),
    .forward_mask_o (result_o.forward_mask),
    .learned_o      (result_o.learned),
    .local_rx_o     (result_o.local_rx),
    .table_full_o   (result_o.table_full)
  );

endmodule

// ===== hdl/mlbf_checker.sv =====
`timescale 1ns / 1ps
`include "mac_learning_bridge_forward_core_assert.svh"

module mlbf_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [mlbf_pkg::MASK_W-1:0] forward_mask_i,
  input logic                        learned_i,
  input logic                        local_rx_i,
  input logic                        table_full_i
);

  logic [mlbf_pkg::MASK_W+2:0] res_beat;

  assign res_beat = {forward_mask_i, learned_i, local_rx_i, table_full_i};

  // hold a stalled result beat
  `MLBF_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(res_beat))

  // one item at a time: no beat right after an accepted one
  `MLBF_ASSERT(a_one_in_flight, in_valid_i && in_ready_i |=> !in_ready_i)

  `MLBF_ASSERT(a_learn_xor_full, out_valid_i |-> !(learned_i && table_full_i))

  // without local source there is no flood, so at most one port
  `MLBF_ASSERT(a_no_flood_remote, out_valid_i && !local_rx_i |-> $onehot0(forward_mask_i))

  `MLBF_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !out_valid_i)

endmodule

bind mac_learning_bridge_forward_core mlbf_checker u_mlbf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (item_i.valid),
  .in_ready_i     (item_i.ready),
  .out_valid_i    (result_o.valid),
  .out_ready_i    (result_o.ready),
  .forward_mask_i (result_o.forward_mask),
  .learned_i      (result_o.learned),
  .local_rx_i     (result_o.local_rx),
  .table_full_i   (result_o.table_full)
);

// ===== tb/tb_mac_learning_bridge_forward_core.sv =====
`timescale 1ns / 1ps

module tb_mac_learning_bridge_forward_core;
  import mlbf_pkg::*;

  localparam int POOL_SIZE      = 80;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = TABLE_ENTRIES + 16;

  localparam logic [MAC_W-1:0] STATION_A = 48'h0200_0000_000A;
  localparam logic [MAC_W-1:0] STATION_B = 48'h0200_0000_000B;
  localparam logic [MAC_W-1:0] STATION_C = 48'h0200_0000_000C;
  localparam logic [MAC_W-1:0] STATION_D = 48'h0200_0000_000D;

  typedef struct packed {
    cmd_e              cmd;
    logic [PORT_W-1:0] port;
    logic [MAC_W-1:0]  src;
    logic [MAC_W-1:0]  dst;
    logic [LEN_W-1:0]  len;
  } bridge_item_t;

  typedef struct packed {
    logic [MASK_W-1:0] fwd;
    logic              learned;
    logic              local_rx;
    logic              table_full;
  } verdict_t;

  typedef enum logic [1:0] {
    DRAIN_FREE,
    DRAIN_RANDOM,
    DRAIN_PERIODIC,
    DRAIN_TOGGLE
  } drain_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  mlbf_item_if   item_if ();
  mlbf_result_if res_if ();
  mlbf_cfg_if    cfg_if ();

  mac_learning_bridge_forward_core u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (res_if),
    .cfg_i    (cfg_if)
  );

  logic              tbl_valid [TABLE_ENTRIES];
  logic [MAC_W-1:0]  tbl_mac   [TABLE_ENTRIES];
  logic [PORT_W-1:0] tbl_port  [TABLE_ENTRIES];
  int unsigned       tbl_fill  = 0;
  logic [MASK_W-1:0] port_mask = PRESENT_RESET;

  logic [MAC_W-1:0]  pool_mac  [POOL_SIZE];
  logic [PORT_W-1:0] pool_home [POOL_SIZE];

  verdict_t    verdict_q [$];
  int          errors       = 0;
  int          n_items      = 0;
  int          n_install    = 0;
  int          n_short      = 0;
  int          n_results    = 0;
  int          n_learn      = 0;
  int          n_full       = 0;
  int          n_flood      = 0;
  int          burst_left   = 0;
  bit          gaps_on      = 1'b1;
  drain_e      drain_mode   = DRAIN_FREE;
  int unsigned drain_tick   = 0;
  int          quiet_cycles = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int lookup_mac(input logic [MAC_W-1:0] mac);
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (tbl_valid[i] && tbl_mac[i] == mac) return i;
    end
    return -1;
  endfunction

  function automatic bit table_insert(input logic [MAC_W-1:0] mac,
                                      input logic [PORT_W-1:0] port);
    if (tbl_fill >= TABLE_ENTRIES) return 1'b0;
    tbl_valid[tbl_fill] = 1'b1;
    tbl_mac[tbl_fill]   = mac;
    tbl_port[tbl_fill]  = port;
    tbl_fill++;
    return 1'b1;
  endfunction

  function automatic verdict_t forward_decision(input bridge_item_t it);
    verdict_t v;
    int       se;
    int       de;
    logic     flood;
    v     = '0;
    flood = 1'b0;
    if (it.cmd == CMD_INSTALL) begin
      if (it.src != BCAST_MAC) begin
        se = lookup_mac(it.src);
        if (se >= 0) tbl_port[se] = it.port;
        else if (table_insert(it.src, it.port)) v.learned = 1'b1;
        else v.table_full = 1'b1;
      end
    end else if (it.len >= HEADER_BYTES) begin
      se = lookup_mac(it.src);
      de = lookup_mac(it.dst);
      if (se >= 0) begin
        v.local_rx = (tbl_port[se] == it.port);
      end else if (it.src != BCAST_MAC) begin
        v.local_rx = 1'b1;
        if (table_insert(it.src, it.port)) v.learned = 1'b1;
        else v.table_full = 1'b1;
      end
      if (it.dst == BCAST_MAC || de < 0) flood = 1'b1;
      else if (tbl_port[de] != it.port) v.fwd = MASK_W'(1) << tbl_port[de];
      if (flood && v.local_rx)
        v.fwd = port_mask & PORT_LIMIT_MASK & ~(MASK_W'(1) << it.port);
    end
    return v;
  endfunction

  function automatic logic [MAC_W-1:0] fresh_mac();
    return MAC_W'({$urandom(), $urandom()});
  endfunction

  function automatic bridge_item_t hdr(input cmd_e c, input int unsigned p,
                                       input logic [MAC_W-1:0] s, input logic [MAC_W-1:0] d,
                                       input int unsigned n);
    bridge_item_t it;
    it.cmd  = c;
    it.port = PORT_W'(p);
    it.src  = s;
    it.dst  = d;
    it.len  = LEN_W'(n);
    return it;
  endfunction

  function automatic bridge_item_t random_item();
    bridge_item_t it;
    int           s;
    int           d;
    int           r;
    s      = $urandom_range(0, POOL_SIZE - 1);
    d      = $urandom_range(0, POOL_SIZE - 1);
    it.cmd = ($urandom_range(0, 99) < 12) ? CMD_INSTALL : CMD_FRAME;
    r = $urandom_range(0, 99);
    if (r < 80) it.src = pool_mac[s];
    else if (r < 86) it.src = BCAST_MAC;
    else it.src = fresh_mac();
    it.port = ($urandom_range(0, 99) < 70) ? pool_home[s] : PORT_W'($urandom_range(0, 7));
    r = $urandom_range(0, 99);
    if (r < 55) it.dst = pool_mac[d];
    else if (r < 70) it.dst = BCAST_MAC;
    else if (r < 78) it.dst = it.src;
    else it.dst = fresh_mac();
    r = $urandom_range(0, 99);
    if (r < 5) it.len = LEN_W'($urandom_range(0, HEADER_BYTES - 1));
    else if (r < 8) it.len = LEN_W'(HEADER_BYTES);
    else if (r < 10) it.len = '1;
    else it.len = LEN_W'($urandom_range(HEADER_BYTES, (1 << LEN_W) - 1));
    if (it.cmd == CMD_INSTALL && $urandom_range(0, 4) == 0) pool_home[s] = it.port;
    return it;
  endfunction

  task automatic send_item(input bridge_item_t it);
    if (burst_left == 0) begin
      repeat (gaps_on ? $urandom_range(1, 8) : 1) @(negedge clk_i);
      burst_left = gaps_on ? $urandom_range(1, 10) : 1000;
    end
    item_if.valid        <= 1'b1;
    item_if.cmd          <= it.cmd;
    item_if.ingress_port <= it.port;
    item_if.src_mac      <= it.src;
    item_if.dst_mac      <= it.dst;
    item_if.frame_length <= it.len;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    burst_left--;
    if (burst_left == 0) item_if.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    if (burst_left != 0) item_if.valid <= 1'b0;
    burst_left = 0;
    while (verdict_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_present_ports(input logic [MASK_W-1:0] mask);
    wait_idle();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= mask;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic run_traffic(input int n, input logic [MASK_W-1:0] mask,
                             input drain_e mode, input bit gaps);
    write_present_ports(mask);
    drain_mode = mode;
    gaps_on    = gaps;
    repeat (n) send_item(random_item());
  endtask

  task automatic test_directed_cases();
    drain_mode = DRAIN_RANDOM;
    send_item(hdr(CMD_FRAME, 1, STATION_A, STATION_B, 0));
    send_item(hdr(CMD_FRAME, 1, STATION_A, STATION_B, HEADER_BYTES - 1));
    send_item(hdr(CMD_FRAME, 1, STATION_A, STATION_B, HEADER_BYTES));
    send_item(hdr(CMD_FRAME, 2, STATION_B, STATION_A, '1));
    send_item(hdr(CMD_FRAME, 1, STATION_A, STATION_A, 60));
    send_item(hdr(CMD_FRAME, 3, STATION_A, BCAST_MAC, 60));
    send_item(hdr(CMD_FRAME, 3, BCAST_MAC, BCAST_MAC, 60));
    send_item(hdr(CMD_INSTALL, 5, BCAST_MAC, '0, 0));
    send_item(hdr(CMD_INSTALL, 4, STATION_C, '1, '1));
    send_item(hdr(CMD_INSTALL, 6, STATION_A, '0, 0));
    send_item(hdr(CMD_FRAME, 6, STATION_A, STATION_C, 60));
    send_item(hdr(CMD_FRAME, 0, '0, BCAST_MAC - 1, 60));
    send_item(hdr(CMD_FRAME, 7, BCAST_MAC - 1, '0, 60));
    send_item(hdr(CMD_FRAME, 5, STATION_D, STATION_D, 60));
    send_item(hdr(CMD_FRAME, 5, STATION_D, STATION_D, 60));
  endtask

  task automatic test_present_ports();
    logic [MASK_W-1:0] masks [6] = '{8'h00, 8'h80, 8'h01, 8'h55, 8'hAA, 8'hFF};
    drain_mode = DRAIN_TOGGLE;
    foreach (masks[i]) begin
      write_present_ports(masks[i]);
      send_item(hdr(CMD_FRAME, 2, STATION_B, fresh_mac(), 64));
      send_item(hdr(CMD_FRAME, 2, STATION_B, STATION_C, 64));
    end
  endtask

  task automatic test_learning_traffic();
    run_traffic(200, 8'hFF, DRAIN_FREE, 1'b0);
    run_traffic(200, 8'hFF, DRAIN_PERIODIC, 1'b1);
  endtask

  task automatic test_table_full();
    logic [MAC_W-1:0] mac;
    write_present_ports(8'hFF);
    drain_mode = DRAIN_RANDOM;
    while (tbl_fill < TABLE_ENTRIES)
      send_item(hdr(CMD_INSTALL, $urandom_range(0, 7), fresh_mac(), fresh_mac(), 0));
    mac = fresh_mac();
    send_item(hdr(CMD_INSTALL, 2, mac, '0, 0));
    send_item(hdr(CMD_FRAME, 3, mac, BCAST_MAC, 64));
    send_item(hdr(CMD_INSTALL, 5, STATION_B, '0, 0));
    send_item(hdr(CMD_FRAME, 5, fresh_mac(), STATION_B, 64));
    send_item(hdr(CMD_FRAME, 1, fresh_mac(), fresh_mac(), 64));
  endtask

  task automatic test_mixed_traffic();
    run_traffic(200, 8'hFF, DRAIN_RANDOM, 1'b1);
    run_traffic(200, MASK_W'($urandom()), DRAIN_TOGGLE, 1'b1);
    run_traffic(200, 8'h00, DRAIN_FREE, 1'b1);
    run_traffic(200, 8'h7E, DRAIN_PERIODIC, 1'b0);
    run_traffic(200, MASK_W'($urandom()), DRAIN_RANDOM, 1'b0);
    run_traffic(200, 8'hFF, DRAIN_TOGGLE, 1'b1);
  endtask

  always @(negedge clk_i) begin
    drain_tick <= drain_tick + 1;
    case (drain_mode)
      DRAIN_FREE:     res_if.ready <= 1'b1;
      DRAIN_RANDOM:   res_if.ready <= ($urandom_range(0, 3) != 0);
      DRAIN_PERIODIC: res_if.ready <= (drain_tick % 32) >= 20;
      default:        res_if.ready <= drain_tick[0];
    endcase
  end

  always @(posedge clk_i) begin : check_results
    verdict_t     want;
    bridge_item_t seen;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        n_results++;
        if (verdict_q.size() == 0) begin
          $error("result beat with no frame outstanding");
          errors++;
        end else begin
          want = verdict_q.pop_front();
          if (res_if.forward_mask !== want.fwd) begin
            $error("forward_mask: expected %h, actual %h", want.fwd, res_if.forward_mask);
            errors++;
          end
          if (res_if.learned !== want.learned) begin
            $error("learned: expected %b, actual %b", want.learned, res_if.learned);
            errors++;
          end
          if (res_if.local_rx !== want.local_rx) begin
            $error("local_rx: expected %b, actual %b", want.local_rx, res_if.local_rx);
            errors++;
          end
          if (res_if.table_full !== want.table_full) begin
            $error("table_full: expected %b, actual %b", want.table_full, res_if.table_full);
            errors++;
          end
        end
      end
      if (item_if.valid && item_if.ready) begin
        seen = hdr(cmd_e'(item_if.cmd), 32'(item_if.ingress_port), item_if.src_mac,
                   item_if.dst_mac, 32'(item_if.frame_length));
        want = forward_decision(seen);
        verdict_q.push_back(want);
        n_items++;
        if (seen.cmd == CMD_INSTALL) n_install++;
        else if (seen.len < HEADER_BYTES) n_short++;
        if (want.learned) n_learn++;
        if (want.table_full) n_full++;
        if ($countones(want.fwd) > 1) n_flood++;
      end
      if (cfg_if.valid && cfg_if.ready) port_mask = cfg_if.data;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (item_if.valid && item_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni               = 1'b0;
    item_if.valid        = 1'b0;
    item_if.cmd          = '0;
    item_if.ingress_port = '0;
    item_if.src_mac      = '0;
    item_if.dst_mac      = '0;
    item_if.frame_length = '0;
    cfg_if.valid         = 1'b0;
    cfg_if.data          = '0;
    res_if.ready         = 1'b0;
    foreach (tbl_valid[i]) begin
      tbl_valid[i] = 1'b0;
      tbl_mac[i]   = '0;
      tbl_port[i]  = '0;
    end
    foreach (pool_mac[i]) begin
      pool_mac[i]  = fresh_mac();
      pool_home[i] = PORT_W'($urandom_range(0, 7));
    end
    pool_mac[0] = '0;
    pool_mac[1] = BCAST_MAC - 1;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_cases();
    test_present_ports();
    test_learning_traffic();
    test_table_full();
    test_mixed_traffic();

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("covered %0d beats in (%0d installs, %0d short frames), %0d results checked",
             n_items, n_install, n_short, n_results);
    $display("table saw %0d learns, %0d skipped on a full table, %0d flooded frames",
             n_learn, n_full, n_flood);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/mlbf_pkg.sv
hdl/mlbf_if.sv
hdl/mlbf_ram.sv
hdl/mlbf_datapath.sv
hdl/mlbf_ctrl.sv
hdl/mac_learning_bridge_forward_core.sv
hdl/mlbf_checker.sv
tb/tb_mac_learning_bridge_forward_core.sv
